### rtl/apl_pkg.sv
// apl_pkg: shared types and constants for the 2-D average pooling block.
// Depends on nothing; used by average_pool_2d under rtl/.
package apl_pkg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_SUM,
        ST_DIV,
        ST_WAIT
    } t_state;

    // register indexes on the configuration port
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_KERNEL = 2'd0;
    localparam t_reg_idx REG_STRIDE = 2'd1;
    localparam t_reg_idx REG_HEIGHT = 2'd2;
    localparam t_reg_idx REG_WIDTH  = 2'd3;

    // register widths and reset values
    localparam int KERNEL_W = 4;
    localparam int STRIDE_W = 4;
    localparam int HEIGHT_W = 11;
    localparam int WIDTH_W  = 11;
    localparam int ROW_W    = 10;

    localparam logic [KERNEL_W-1:0] KERNEL_RST = 4'd2;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 4'd2;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd1024;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;

    // rows per plane never exceed this
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 11'd1024;

endpackage

### rtl/apl_div.sv
// apl_div: restoring divider, one quotient bit per cycle.
// Unsigned numerator and denominator; no package dependencies.
module apl_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one shift-subtract step
    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

### rtl/apl_cell.sv
// apl_cell: one column-sum cell of the window chain.
// Holds the vertical sum of one column and adds it into the passing window sum.
module apl_cell #(
    parameter int COL_W = 19,
    parameter int TOT_W = 22
) (
    input  logic                    i_clk,
    input  logic                    i_shift,
    input  logic                    i_en,
    input  logic signed [COL_W-1:0] i_col_sum,
    input  logic signed [TOT_W-1:0] i_part,
    output logic signed [COL_W-1:0] o_col_sum,
    output logic signed [TOT_W-1:0] o_part
);

    logic signed [COL_W-1:0] r_col_sum;

    // take the neighbor's column on each new sample
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col_sum <= i_col_sum;
        end
    end

    // add this column when it lies inside the window
    assign o_part    = i_en ? i_part + TOT_W'(r_col_sum) : i_part;
    assign o_col_sum = r_col_sum;

endmodule

### rtl/average_pool_2d.sv
// average_pool_2d: 2-D average pooling over a raster stream of Q8.8 samples, no padding.
// Depends on apl_pkg, apl_cell (window chain) and apl_div (mean and stride checks).
// A sample is taken in ST_IDLE; the line store (one bank per row, one read port each) is
// read at that column; in ST_COL the vertical column sum then enters a chain of cells.
// A sample that closes no window frees the input after ST_COL. One that closes a window
// goes on through ST_SUM for the chain sum, ST_DIV to start the bit-serial dividers and
// ST_WAIT while they run; the mean divider works on SAMPLE_BITS + 2*clog2(MAX_KERNEL)
// bits (22 at default parameters), and the mean is loaded only on the stride grid.
// Results wait in an output register, so a stalled output holds the input only when
// a new mean is ready while the previous one still waits.
// The line store needs no clearing after reset; registers are at byte addresses 0,4,8,12.
module average_pool_2d #(
    parameter int MAX_KERNEL  = 8,
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // result output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output logic                          o_last_of_plane,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int XW    = (CW + 1 > apl_pkg::WIDTH_W) ? CW + 1 : apl_pkg::WIDTH_W;
    localparam int EW    = XW + 2;
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int BW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int DW    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int CSW   = SAMPLE_BITS + $clog2(MAX_KERNEL);
    localparam int TW    = SAMPLE_BITS + 2 * $clog2(MAX_KERNEL);
    localparam int RNW   = apl_pkg::ROW_W + 1;
    localparam int CNW   = CW + 1;

    // configuration registers
    logic [apl_pkg::KERNEL_W-1:0] r_kernel;
    logic [apl_pkg::STRIDE_W-1:0] r_stride;
    logic [apl_pkg::HEIGHT_W-1:0] r_height;
    logic [apl_pkg::WIDTH_W-1:0]  r_width;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= apl_pkg::KERNEL_RST;
            r_stride <= apl_pkg::STRIDE_RST;
            r_height <= apl_pkg::HEIGHT_RST;
            r_width  <= apl_pkg::WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                apl_pkg::REG_KERNEL: r_kernel <= pwdata[apl_pkg::KERNEL_W-1:0];
                apl_pkg::REG_STRIDE: r_stride <= pwdata[apl_pkg::STRIDE_W-1:0];
                apl_pkg::REG_HEIGHT: r_height <= pwdata[apl_pkg::HEIGHT_W-1:0];
                apl_pkg::REG_WIDTH:  r_width  <= pwdata[apl_pkg::WIDTH_W-1:0];
                default:             r_width  <= r_width;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            apl_pkg::REG_KERNEL: prdata = 32'(r_kernel);
            apl_pkg::REG_STRIDE: prdata = 32'(r_stride);
            apl_pkg::REG_HEIGHT: prdata = 32'(r_height);
            apl_pkg::REG_WIDTH:  prdata = 32'(r_width);
            default:             prdata = '0;
        endcase
    end

    // effective sizes after clamping
    logic [KW-1:0]               k_eff;
    logic [apl_pkg::STRIDE_W-1:0] s_eff;
    logic [apl_pkg::HEIGHT_W-1:0] h_eff;
    logic [XW-1:0]               w_eff;

    always_comb begin
        if (r_kernel == '0) begin
            k_eff = KW'(1);
        end else if (int'(r_kernel) > MAX_KERNEL) begin
            k_eff = KW'(MAX_KERNEL);
        end else begin
            k_eff = KW'(r_kernel);
        end
        s_eff = (r_stride == '0) ? apl_pkg::STRIDE_W'(1) : r_stride;
        if (r_height == '0) begin
            h_eff = apl_pkg::HEIGHT_W'(1);
        end else if (r_height > apl_pkg::HEIGHT_LIMIT) begin
            h_eff = apl_pkg::HEIGHT_LIMIT;
        end else begin
            h_eff = r_height;
        end
        if (r_width == '0) begin
            w_eff = XW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(r_width);
        end
    end

    // state and handshake
    apl_pkg::t_state r_state;
    apl_pkg::t_state n_state;
    logic            accept;
    logic            cell_shift;
    logic            div_start;
    logic            out_load;
    logic            win_ok;
    logic            any_busy;
    logic            hit;
    logic            out_free;
    logic            r_ov;

    assign o_ready  = (r_state == apl_pkg::ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;

    // position counters
    logic [CW-1:0]               r_col;
    logic [apl_pkg::ROW_W-1:0]   r_row;
    logic [BW-1:0]               r_bank;
    logic [CW-1:0]               col_pre;
    logic [apl_pkg::ROW_W-1:0]   row_pre;
    logic [BW-1:0]               bank_pre;
    logic [CW-1:0]               n_col;
    logic [apl_pkg::ROW_W-1:0]   n_row;
    logic [BW-1:0]               n_bank;
    logic [apl_pkg::HEIGHT_W-1:0] row_inc;
    logic [BW-1:0]               bank_inc;
    logic                        c_wrap;

    // wrap before the sample (covers a shrunken size) and after it
    always_comb begin
        c_wrap   = EW'(r_col) >= EW'(w_eff);
        col_pre  = c_wrap ? '0 : r_col;
        row_inc  = apl_pkg::HEIGHT_W'(r_row) + (c_wrap ? apl_pkg::HEIGHT_W'(1) : '0);
        bank_inc = r_bank;
        if (c_wrap) begin
            bank_inc = (r_bank == BW'(MAX_KERNEL - 1)) ? '0 : r_bank + 1'b1;
        end
        if (row_inc >= h_eff) begin
            row_pre  = '0;
            bank_pre = '0;
        end else begin
            row_pre  = row_inc[apl_pkg::ROW_W-1:0];
            bank_pre = bank_inc;
        end

        n_col  = col_pre;
        n_row  = row_pre;
        n_bank = bank_pre;
        if (EW'(col_pre) + EW'(1) >= EW'(w_eff)) begin
            n_col = '0;
            if (apl_pkg::HEIGHT_W'(row_pre) + apl_pkg::HEIGHT_W'(1) >= h_eff) begin
                n_row  = '0;
                n_bank = '0;
            end else begin
                n_row  = row_pre + 1'b1;
                n_bank = (bank_pre == BW'(MAX_KERNEL - 1)) ? '0 : bank_pre + 1'b1;
            end
        end else begin
            n_col = col_pre + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bank <= n_bank;
        end
    end

    // current item
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [CW-1:0]                 r_c;
    logic [apl_pkg::ROW_W-1:0]     r_r;
    logic [BW-1:0]                 r_bk;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_c      <= col_pre;
            r_r      <= row_pre;
            r_bk     <= bank_pre;
        end
    end

    // line store: one bank per row, written and read at the sample's column
    logic signed [SAMPLE_BITS-1:0] rd_data [MAX_KERNEL];

    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
        logic signed [SAMPLE_BITS-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (accept) begin
                if (bank_pre == BW'(b)) begin
                    mem[col_pre] <= i_sample;
                end
                r_rd <= mem[col_pre];
            end
        end

        assign rd_data[b] = r_rd;
    end

    // vertical sum of the new column over the last k rows
    logic signed [CSW-1:0] col_sum;

    always_comb begin
        int idx;
        col_sum = CSW'(r_sample);
        for (int dr = 1; dr < MAX_KERNEL; dr++) begin
            idx = int'(r_bk) + MAX_KERNEL - dr;
            if (idx >= MAX_KERNEL) begin
                idx = idx - MAX_KERNEL;
            end
            if (dr < int'(k_eff)) begin
                col_sum = col_sum + CSW'(rd_data[BW'(idx)]);
            end
        end
    end

    // chain of column-sum cells
    logic signed [CSW-1:0] chain_col  [MAX_KERNEL+1];
    logic signed [TW-1:0]  chain_part [MAX_KERNEL+1];

    assign chain_col[0]  = col_sum;
    assign chain_part[0] = '0;

    for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
        apl_cell #(
            .COL_W (CSW),
            .TOT_W (TW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (cell_shift),
            .i_en      (j < int'(k_eff)),
            .i_col_sum (chain_col[j]),
            .i_part    (chain_part[j]),
            .o_col_sum (chain_col[j+1]),
            .o_part    (chain_part[j+1])
        );
    end

    // window checks, latched in the column cycle
    logic r_last;
    logic [RNW-1:0] r_num_r;
    logic [CNW-1:0] r_num_c;
    logic signed [TW-1:0] r_total;
    logic [EW-1:0] row_off;
    logic [EW-1:0] col_off;

    always_comb begin
        row_off = EW'(r_r) + EW'(1) - EW'(k_eff);
        col_off = EW'(r_c) + EW'(1) - EW'(k_eff);
        win_ok  = (EW'(k_eff) <= EW'(h_eff)) && (EW'(k_eff) <= EW'(w_eff)) &&
                  (EW'(r_r) + EW'(1) >= EW'(k_eff)) && (EW'(r_c) + EW'(1) >= EW'(k_eff));
    end

    always_ff @(posedge i_clk) begin
        if (cell_shift) begin
            r_num_r <= row_off[RNW-1:0];
            r_num_c <= col_off[CNW-1:0];
            r_last  <= (EW'(r_r) + EW'(1) + EW'(s_eff) > EW'(h_eff)) &&
                       (EW'(r_c) + EW'(1) + EW'(s_eff) > EW'(w_eff));
        end
        if (r_state == apl_pkg::ST_SUM) begin
            r_total <= chain_part[MAX_KERNEL];
        end
    end

    // dividers: mean, row phase, column phase
    logic [TW-1:0]   mag;
    logic [DW-1:0]   kk;
    logic [TW-1:0]   mean_q;
    logic [DW-1:0]   mean_rem;
    logic [RNW-1:0]  row_q;
    logic [apl_pkg::STRIDE_W-1:0] row_rem;
    logic [CNW-1:0]  col_q;
    logic [apl_pkg::STRIDE_W-1:0] col_rem;
    logic            busy_m;
    logic            busy_r;
    logic            busy_c;

    assign mag = r_total[TW-1] ? TW'(-r_total) : TW'(r_total);
    assign kk  = DW'(k_eff) * DW'(k_eff);

    apl_div #(.NUM_W(TW), .DEN_W(DW)) u_div_mean (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_num (mag), .i_den (kk),
        .o_busy (busy_m), .o_quot (mean_q), .o_rem (mean_rem)
    );

    apl_div #(.NUM_W(RNW), .DEN_W(apl_pkg::STRIDE_W)) u_div_row (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_num (r_num_r), .i_den (s_eff),
        .o_busy (busy_r), .o_quot (row_q), .o_rem (row_rem)
    );

    apl_div #(.NUM_W(CNW), .DEN_W(apl_pkg::STRIDE_W)) u_div_col (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_num (r_num_c), .i_den (s_eff),
        .o_busy (busy_c), .o_quot (col_q), .o_rem (col_rem)
    );

    assign any_busy = busy_m || busy_r || busy_c;
    assign hit      = (row_rem == '0) && (col_rem == '0);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        cell_shift = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            apl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = apl_pkg::ST_COL;
                end
            end
            apl_pkg::ST_COL: begin
                cell_shift = 1'b1;
                n_state    = win_ok ? apl_pkg::ST_SUM : apl_pkg::ST_IDLE;
            end
            apl_pkg::ST_SUM: begin
                n_state = apl_pkg::ST_DIV;
            end
            apl_pkg::ST_DIV: begin
                div_start = 1'b1;
                n_state   = apl_pkg::ST_WAIT;
            end
            apl_pkg::ST_WAIT: begin
                if (!any_busy) begin
                    if (!hit) begin
                        n_state = apl_pkg::ST_IDLE;
                    end else if (out_free) begin
                        out_load = 1'b1;
                        n_state  = apl_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = apl_pkg::ST_IDLE;
        endcase
    end

    // output register
    logic [TW-1:0] mean_s;
    logic          r_neg;

    assign r_neg  = r_total[TW-1];
    assign mean_s = r_neg ? TW'(-mean_q) : mean_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_average       <= mean_s[SAMPLE_BITS-1:0];
            o_last_of_plane <= r_last;
        end
    end

    assign o_valid = r_ov;

    // checks
    a_accept_to_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == apl_pkg::ST_COL)
        else $error("accepted sample did not enter the column step");

    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !any_busy)
        else $error("input ready while a divider is running");

    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bank) < MAX_KERNEL)
        else $error("line store bank index out of range");

endmodule
